// ----- hdl/stsc_pkg.sv -----
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types and constants for the servo turnout slew controller.
// ----------------------------------------------------------------------------
package stsc_pkg;

    localparam int unsigned ANGLE_W     = 8;
    localparam int unsigned DELAY_W     = 12;
    localparam int unsigned DEBOUNCE_W  = 8;
    localparam int unsigned STABLE_W    = 9;
    localparam int unsigned REMOTE_W    = 8;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned ROUTE_W     = 2;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam int unsigned DEFAULT_ANGLE_C = 90;

    localparam logic [DELAY_W-1:0]    STEP_DELAY_RST  = 12'd20;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST    = 8'd50;
    localparam logic [DELAY_W-1:0]    MIN_STEP_DELAY  = 12'd5;
    localparam logic [DELAY_W-1:0]    STEP_MAX        = 12'd4095;
    localparam logic [STABLE_W-1:0]   STABLE_MAX      = 9'd511;
    localparam logic [REMOTE_W-1:0]   REMOTE_RST      = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_REMOTE = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRAIGHT  = 2'd0,
        CFG_DIVERGENT = 2'd1,
        CFG_STEP      = 2'd2,
        CFG_DEBOUNCE  = 2'd3
    } t_cfg_idx;

    localparam logic [ROUTE_W-1:0] ROUTE_MOVING    = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_STRAIGHT  = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_DIVERGENT = 2'd2;
    localparam logic [ROUTE_W-1:0] ROUTE_UNUSED    = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0]    straight_limit;
        logic [ANGLE_W-1:0]    divergent_limit;
        logic [DELAY_W-1:0]    step_delay;
        logic [DEBOUNCE_W-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        logic               servo_active;
        logic [ROUTE_W-1:0] route_status;
        logic               remote_status_bit;
    } t_result;

endpackage

// ----- hdl/stsc_cfg.sv -----
// ----------------------------------------------------------------------------
// stsc_cfg
// Configuration register file: route limits, step delay, debounce time.
// ----------------------------------------------------------------------------
module stsc_cfg
    import stsc_pkg::*;
#(
    parameter int unsigned DEFAULT_ANGLE = DEFAULT_ANGLE_C
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [DELAY_W-1:0]   i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.straight_limit  <= ANGLE_W'(DEFAULT_ANGLE);
            r_cfg.divergent_limit <= ANGLE_W'(DEFAULT_ANGLE);
            r_cfg.step_delay      <= STEP_DELAY_RST;
            r_cfg.debounce_ms     <= DEBOUNCE_RST;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_index))
                CFG_STRAIGHT:  r_cfg.straight_limit  <= i_data[ANGLE_W-1:0];
                CFG_DIVERGENT: r_cfg.divergent_limit <= i_data[ANGLE_W-1:0];
                CFG_STEP:      r_cfg.step_delay      <= i_data;
                CFG_DEBOUNCE:  r_cfg.debounce_ms     <= i_data[DEBOUNCE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/stsc_core.sv -----
// ----------------------------------------------------------------------------
// stsc_core
// Controller state and the combinational update for one item: debounce,
// target toggle, one-degree slew step and settle detection.
// ----------------------------------------------------------------------------
module stsc_core
    import stsc_pkg::*;
#(
    parameter int unsigned DEFAULT_ANGLE = DEFAULT_ANGLE_C
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic                i_button_level,
    input  logic [REMOTE_W-1:0] i_remote_byte,
    input  t_cfg                i_cfg,
    output t_result             o_result
);

    logic [ANGLE_W-1:0]  r_pos, n_pos;
    logic [ANGLE_W-1:0]  r_target, n_target;
    logic                r_moving, n_moving;
    logic                r_attached, n_attached;
    logic                r_remote_bit, n_remote_bit;
    logic [REMOTE_W-1:0] r_last_remote, n_last_remote;
    logic                r_prev_level, n_prev_level;
    logic                r_stable_level, n_stable_level;
    logic                r_press_seen, n_press_seen;
    logic [STABLE_W-1:0] r_stable_ticks, n_stable_ticks;
    logic [DELAY_W-1:0]  r_step_ticks, n_step_ticks;

    logic [ANGLE_W:0]    w_mid_sum;
    logic [DELAY_W-1:0]  w_eff_delay;
    logic                w_toggle;

    assign w_mid_sum   = {1'b0, i_cfg.straight_limit} + {1'b0, i_cfg.divergent_limit};
    assign w_eff_delay = (i_cfg.step_delay < MIN_STEP_DELAY) ? MIN_STEP_DELAY
                                                             : i_cfg.step_delay;

    always_comb begin
        n_pos          = r_pos;
        n_target       = r_target;
        n_moving       = r_moving;
        n_attached     = r_attached;
        n_remote_bit   = r_remote_bit;
        n_last_remote  = r_last_remote;
        n_prev_level   = r_prev_level;
        n_stable_level = r_stable_level;
        n_press_seen   = r_press_seen;
        n_stable_ticks = r_stable_ticks;
        n_step_ticks   = r_step_ticks;
        w_toggle       = 1'b0;

        unique case (t_cmd'(i_cmd))
            CMD_TICK: begin
                if (i_button_level != r_prev_level) begin
                    n_stable_ticks = '0;
                end else if (r_stable_ticks != STABLE_MAX) begin
                    n_stable_ticks = r_stable_ticks + 9'd1;
                end
                n_prev_level = i_button_level;
                if ((n_stable_ticks > {1'b0, i_cfg.debounce_ms}) &&
                    (i_button_level != r_stable_level)) begin
                    n_stable_level = i_button_level;
                    if (!i_button_level) begin
                        n_press_seen = 1'b1;
                    end else if (r_press_seen) begin
                        w_toggle     = 1'b1;
                        n_press_seen = 1'b0;
                    end
                end
            end
            CMD_START: begin
                n_attached   = 1'b1;
                n_target     = i_cfg.straight_limit;
                n_pos        = w_mid_sum[ANGLE_W:1];
                n_step_ticks = '0;
            end
            CMD_REMOTE: begin
                if (i_remote_byte != r_last_remote) begin
                    w_toggle      = 1'b1;
                    n_last_remote = i_remote_byte;
                end
            end
            default: ;
        endcase

        // toggle looks at the position before any slew step of this tick
        if (w_toggle) begin
            n_attached = 1'b1;
            n_moving   = 1'b1;
            if (r_pos == i_cfg.straight_limit) begin
                n_target = i_cfg.divergent_limit;
            end else if (r_pos == i_cfg.divergent_limit) begin
                n_target = i_cfg.straight_limit;
            end
        end

        if (t_cmd'(i_cmd) == CMD_TICK) begin
            if (r_step_ticks != STEP_MAX) begin
                n_step_ticks = r_step_ticks + 12'd1;
            end
            if (n_step_ticks >= w_eff_delay) begin
                n_step_ticks = '0;
                if (r_pos < n_target) begin
                    n_pos = r_pos + 8'd1;
                end else if (r_pos > n_target) begin
                    n_pos = r_pos - 8'd1;
                end
            end
            if (n_pos == n_target) begin
                n_attached = 1'b0;
                n_moving   = 1'b0;
                if (n_pos == i_cfg.straight_limit) begin
                    n_remote_bit = 1'b0;
                end else if (n_pos == i_cfg.divergent_limit) begin
                    n_remote_bit = 1'b1;
                end
            end
        end

        o_result.servo_angle       = n_pos;
        o_result.servo_active      = n_attached;
        o_result.remote_status_bit = n_remote_bit;
        if (n_moving) begin
            o_result.route_status = ROUTE_MOVING;
        end else if (n_pos == i_cfg.straight_limit) begin
            o_result.route_status = ROUTE_STRAIGHT;
        end else begin
            o_result.route_status = ROUTE_DIVERGENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= ANGLE_W'(DEFAULT_ANGLE);
            r_target       <= ANGLE_W'(DEFAULT_ANGLE);
            r_moving       <= 1'b0;
            r_attached     <= 1'b0;
            r_remote_bit   <= 1'b0;
            r_last_remote  <= REMOTE_RST;
            r_prev_level   <= 1'b1;
            r_stable_level <= 1'b1;
            r_press_seen   <= 1'b0;
            r_stable_ticks <= '0;
            r_step_ticks   <= '0;
        end else if (i_adv) begin
            r_pos          <= n_pos;
            r_target       <= n_target;
            r_moving       <= n_moving;
            r_attached     <= n_attached;
            r_remote_bit   <= n_remote_bit;
            r_last_remote  <= n_last_remote;
            r_prev_level   <= n_prev_level;
            r_stable_level <= n_stable_level;
            r_press_seen   <= n_press_seen;
            r_stable_ticks <= n_stable_ticks;
            r_step_ticks   <= n_step_ticks;
        end
    end

    // a move always runs with the drive attached
    a_moving_attached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> r_attached)
        else $error("moving with drive detached");

    // a press is only pending while the accepted level is low
    a_press_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press_seen |-> !r_stable_level)
        else $error("press pending with released level");

    // the position changes by at most one degree per tick
    a_one_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (t_cmd'(i_cmd) == CMD_TICK)) |=>
            ((r_pos == $past(r_pos)) || (r_pos == $past(r_pos) + 8'd1) ||
             (r_pos == $past(r_pos) - 8'd1)))
        else $error("slew step larger than one degree");

endmodule

// ----- hdl/servo_turnout_slew_controller.sv -----
// ----------------------------------------------------------------------------
// servo_turnout_slew_controller
// Two-position servo slew controller with button debounce and remote toggle.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result item. The block takes one
// item per clock while the output is not stalled: the item is registered, the
// whole state update (debounce, toggle, slew step, settle) is done in one
// combinational pass of the core, and the result is registered. A full output
// register does not block input while the result is being taken in the same
// cycle. The configuration port is always ready and writes take effect on the
// next item.
module servo_turnout_slew_controller
    import stsc_pkg::*;
#(
    parameter int unsigned DEFAULT_ANGLE = DEFAULT_ANGLE_C
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic                 i_button_level,
    input  logic [REMOTE_W-1:0]  i_remote_byte,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ANGLE_W-1:0]   o_servo_angle,
    output logic                 o_servo_active,
    output logic [ROUTE_W-1:0]   o_route_status,
    output logic                 o_remote_status_bit,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_data
);

    logic                r_in_valid;
    logic [CMD_W-1:0]    r_cmd;
    logic                r_button_level;
    logic [REMOTE_W-1:0] r_remote_byte;
    logic                r_out_valid;
    t_result             r_result;

    t_cfg                w_cfg;
    t_result             w_result;
    logic                w_out_free;
    logic                w_adv;

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    stsc_cfg #(
        .DEFAULT_ANGLE (DEFAULT_ANGLE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    stsc_core #(
        .DEFAULT_ANGLE (DEFAULT_ANGLE)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_cmd          (r_cmd),
        .i_button_level (r_button_level),
        .i_remote_byte  (r_remote_byte),
        .i_cfg          (w_cfg),
        .o_result       (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd          <= i_cmd;
            r_button_level <= i_button_level;
            r_remote_byte  <= i_remote_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_servo_angle       = r_result.servo_angle;
    assign o_servo_active      = r_result.servo_active;
    assign o_route_status      = r_result.route_status;
    assign o_remote_status_bit = r_result.remote_status_bit;

    // a held item must never be overwritten by the input side
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |-> o_in_stall)
        else $error("pending item lost");

    // an item that leaves the input register lands in the result register
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("result dropped after update");

    // route code is never the unused value
    a_route_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_route_status != ROUTE_UNUSED))
        else $error("invalid route status");

    // a result that reports moving has the drive attached
    a_moving_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_route_status == ROUTE_MOVING)) |-> o_servo_active)
        else $error("moving reported with drive detached");

endmodule
